### rtl/core/largest_empty_square_finder_core_defines.svh
// Assertion macros shared by the largest empty square finder RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_CORE_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is high.
`define LESF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define LESF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LESF_ASSERT(lbl, clk, rst, prop, msg)
`define LESF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/core/lesf_pkg.sv
// Types and constants for the largest empty square finder.
// No dependencies; imported by lesf_best and the core top level.
`timescale 1ns / 1ps

package lesf_pkg;

  localparam int SIZE_W     = 11;
  localparam int ROW_OUT_W  = 10;
  localparam int COL_OUT_W  = 10;
  localparam int CHAR_W     = 8;
  localparam int CFG_DATA_W = 11;

  localparam logic [SIZE_W-1:0] SIZE_MAX          = '1;
  localparam logic [SIZE_W-1:0] MAP_WIDTH_RST     = 11'd1;
  localparam logic [CHAR_W-1:0] OBSTACLE_CHAR_RST = 8'd111;

  typedef enum logic [0:0] {
    REG_MAP_WIDTH     = 1'b0,
    REG_OBSTACLE_CHAR = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic              last_cell;
  } cell_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]    square_size;
    logic [ROW_OUT_W-1:0] top_row;
    logic [COL_OUT_W-1:0] left_col;
  } result_item_t;

  // Control that travels with a candidate square into the best tracker.
  typedef struct packed {
    logic valid;
    logic last;
  } cand_ctl_t;

endpackage

### rtl/core/largest_empty_square_finder_core.sv
// Largest empty square finder core: one map cell per item, one result per map.
// Throughput: one item per cycle, but input stalls while a map's last cell waits
// for the previous result to be taken. The last cell goes through stage 1 and the
// stage 2 register in lesf_best into the result register. Reset clears counters,
// neighbor and best registers; the row buffer is not cleared (written before read).
`timescale 1ns / 1ps
`include "largest_empty_square_finder_core_defines.svh"

module largest_empty_square_finder_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cell_valid,
  output logic                            cell_ready,
  input  lesf_pkg::cell_item_t            cell_data,
  output logic                            result_valid,
  input  logic                            result_ready,
  output lesf_pkg::result_item_t          result,
  input  logic                            cfg_wr_en,
  input  lesf_pkg::cfg_reg_e              cfg_index,
  input  logic [lesf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lesf_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  // Wide enough for MAX_WIDTH itself and for the width register.
  localparam int WW = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;

  localparam logic [WW-1:0]    W_MAX   = WW'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] ROW_TOP = ROW_W'(MAX_HEIGHT - 1);

  // Configuration
  logic [CFG_DATA_W-1:0] map_width;
  logic [CHAR_W-1:0]     obstacle_char;

  // Cell position counters (input side)
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;

  // Stage 1: row buffer read data is back, size is computed and written back
  logic              s1_valid;
  logic              s1_last;
  logic [CHAR_W-1:0] s1_char;
  logic [COL_W-1:0]  s1_col;
  logic [ROW_W-1:0]  s1_row;
  logic              s1_fwd;
  logic [SIZE_W-1:0] fwd_data;
  logic [SIZE_W-1:0] rd_data;

  // Neighbors in the current row
  logic [SIZE_W-1:0] left_size;
  logic [SIZE_W-1:0] diag_size;

  // Row buffer: size of each column's square in the previous row
  logic [SIZE_W-1:0] prev_row_sizes [MAX_WIDTH];

  logic              hold;
  logic              accept;
  logic              s1_go;
  logic              row_end;
  logic [WW-1:0]     w_eff;
  logic [WW-1:0]     col_inc;
  logic [SIZE_W-1:0] up, left, diag, min_ud, min_all, s_cur;
  cand_ctl_t         cand_ctl;

  assign cell_ready = !hold;
  assign accept     = cell_valid && cell_ready;
  assign s1_go      = s1_valid && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= MAP_WIDTH_RST;
      obstacle_char <= OBSTACLE_CHAR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:     map_width     <= cfg_wdata;
        REG_OBSTACLE_CHAR: obstacle_char <= cfg_wdata[CHAR_W-1:0];
      endcase
    end
  end

  // Effective width: zero acts as one, above MAX_WIDTH clamps.
  always_comb begin
    if (map_width == '0) begin
      w_eff = WW'(1);
    end else if (WW'(map_width) > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = WW'(map_width);
    end
    col_inc = WW'(col_count) + WW'(1);
    row_end = col_inc >= w_eff;
  end

  // Position counters advance at acceptance; the last cell restarts the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (cell_data.last_cell) begin
        col_count <= '0;
        row_count <= '0;
      end else if (row_end) begin
        col_count <= '0;
        if (row_count < ROW_TOP) begin
          row_count <= row_count + ROW_W'(1);
        end
      end else begin
        col_count <= COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Forward when the item in stage 1 writes the entry being read now
  // (only when both are in column 0, as in a one-column map).
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last  <= cell_data.last_cell;
      s1_char  <= cell_data.cell_char;
      s1_col   <= col_count;
      s1_row   <= row_count;
      s1_fwd   <= s1_go && (s1_col == col_count);
      fwd_data <= s_cur;
    end
  end

  // Row buffer port: read at acceptance, write back when stage 1 moves on.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= prev_row_sizes[col_count];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      prev_row_sizes[s1_col] <= s_cur;
    end
  end

  // Square recurrence: 0 on an obstacle, else 1 + min(up, left, diag), saturating at SIZE_MAX.
  always_comb begin
    up      = (s1_row != '0) ? (s1_fwd ? fwd_data : rd_data) : '0;
    left    = (s1_col != '0) ? left_size : '0;
    diag    = ((s1_row != '0) && (s1_col != '0)) ? diag_size : '0;
    min_ud  = (up < left) ? up : left;
    min_all = (min_ud < diag) ? min_ud : diag;
    if (s1_char == obstacle_char) begin
      s_cur = '0;
    end else if (min_all == SIZE_MAX) begin
      s_cur = SIZE_MAX;
    end else begin
      s_cur = min_all + SIZE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
    end else if (s1_go) begin
      left_size <= s_cur;
      diag_size <= up;
    end
  end

  assign cand_ctl.valid = s1_valid;
  assign cand_ctl.last  = s1_last;

  lesf_best #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_best (
    .clk          (clk),
    .rst          (rst),
    .cand_ctl     (cand_ctl),
    .cand_size    (s_cur),
    .cand_row     (s1_row),
    .cand_col     (s1_col),
    .hold         (hold),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `LESF_ASSERT(a_row_wrap, clk, rst, accept && row_end |=> col_count == '0, "column did not wrap at row end")
  `LESF_ASSERT(a_map_restart, clk, rst, accept && cell_data.last_cell |=> col_count == '0 && row_count == '0, "counters not cleared")
  `LESF_ASSERT(a_s1_holds, clk, rst, s1_valid && hold |=> s1_valid && $stable(s1_col) && $stable(s1_row), "stage 1 item lost while held")
  `LESF_ASSERT(a_fwd_valid, clk, rst, s1_fwd && s1_valid |-> s1_col == '0, "forward outside a one-column map")

endmodule

### rtl/core/lesf_best.sv
// Best-square tracker: derives the top-left corner of each candidate,
// keeps the winner and owns the result register. Depends on lesf_pkg.
`timescale 1ns / 1ps
`include "largest_empty_square_finder_core_defines.svh"

module lesf_best #(
  parameter int ROW_W = 10,
  parameter int COL_W = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lesf_pkg::cand_ctl_t        cand_ctl,
  input  logic [lesf_pkg::SIZE_W-1:0] cand_size,
  input  logic [ROW_W-1:0]           cand_row,
  input  logic [COL_W-1:0]           cand_col,
  output logic                       hold,
  output logic                       result_valid,
  input  logic                       result_ready,
  output lesf_pkg::result_item_t     result
);
  import lesf_pkg::*;

  localparam int RC_W = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int TW   = ((RC_W > SIZE_W) ? RC_W : SIZE_W) + 1;

  cand_ctl_t          s2_ctl;
  logic [SIZE_W-1:0]  s2_size;
  logic [ROW_W-1:0]   s2_row;
  logic [COL_W-1:0]   s2_col;

  logic [SIZE_W-1:0]  best_size, best_size_next;
  logic [ROW_W-1:0]   best_row, best_row_next;
  logic [COL_W-1:0]   best_col, best_col_next;

  logic [TW-1:0]      row_inc, col_inc, size_ext;
  logic [ROW_W-1:0]   top;
  logic [COL_W-1:0]   lft;
  logic               better, leave;

  assign hold  = s2_ctl.valid && s2_ctl.last && result_valid && !result_ready;
  assign leave = s2_ctl.valid && !hold;

  // Top-left corner from the bottom-right cell and the size, floored at 0.
  always_comb begin
    row_inc  = TW'(s2_row) + TW'(1);
    col_inc  = TW'(s2_col) + TW'(1);
    size_ext = TW'(s2_size);
    top = (row_inc >= size_ext) ? ROW_W'(row_inc - size_ext) : '0;
    lft = (col_inc >= size_ext) ? COL_W'(col_inc - size_ext) : '0;
    better = (s2_size != '0) &&
             ((s2_size > best_size) ||
              ((s2_size == best_size) &&
               ((top < best_row) || ((top == best_row) && (lft < best_col)))));
    best_size_next = better ? s2_size : best_size;
    best_row_next  = better ? top : best_row;
    best_col_next  = better ? lft : best_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (!hold) begin
      s2_ctl <= cand_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s2_size <= cand_size;
      s2_row  <= cand_row;
      s2_col  <= cand_col;
    end
  end

  // Best square; cleared once a map's result is taken into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_size <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else if (leave) begin
      if (s2_ctl.last) begin
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else begin
        best_size <= best_size_next;
        best_row  <= best_row_next;
        best_col  <= best_col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (leave && s2_ctl.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (leave && s2_ctl.last) begin
      result.square_size <= best_size_next;
      result.top_row     <= ROW_OUT_W'(best_row_next);
      result.left_col    <= COL_OUT_W'(best_col_next);
    end
  end

  `LESF_ASSERT(a_best_cleared, clk, rst, leave && s2_ctl.last |=> best_size == '0, "best not cleared after map end")
  `LESF_ASSERT(a_best_grows, clk, rst, leave && !s2_ctl.last |=> best_size >= $past(best_size), "best size shrank within a map")
  `LESF_ASSERT(a_hold_needs_full, clk, rst, hold |-> result_valid && s2_ctl.last, "pipeline held without pending result")

endmodule

### verif/largest_empty_square_finder_core_tb.sv
// Self-checking testbench for largest_empty_square_finder_core.
// Streams character maps, predicts the largest obstacle-free square per map
// and checks every result item; depends on lesf_pkg and the core RTL only.
`timescale 1ns / 1ps

module largest_empty_square_finder_core_tb;
  import lesf_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  // Settling slack after the last pending result is taken.
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_CELLS   = 320;
  localparam int RAND_MAPS    = 12;
  localparam int N_DIRECTED   = 31;

  logic                  clk;
  logic                  rst;
  logic                  cell_valid;
  logic                  cell_ready;
  cell_item_t            cell_data;
  logic                  result_valid;
  logic                  result_ready;
  result_item_t          result_data;
  logic                  cfg_wr_en;
  cfg_reg_e              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  largest_empty_square_finder_core uut (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .cell_data    (cell_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Square predictor: mirrors the registers and the per-map scan state.
  // ---------------------------------------------------------------------------
  int unsigned width_cfg = MAP_WIDTH_RST;
  int unsigned obst_cfg  = OBSTACLE_CHAR_RST;

  // Line buffer is only read for columns already written in the same map,
  // so its starting contents never matter.
  int unsigned line_sizes [MAX_W];
  int unsigned run_left, run_diag, col_pos, row_pos;
  int unsigned best_sz, best_r, best_c;

  result_item_t pending_squares [$];

  int mismatches      = 0;
  int cells_sent      = 0;
  int maps_sent       = 0;
  int squares_checked = 0;
  int settings_used   = 0;
  int idle_mode       = 0;   // 0: sender light, 1: receiver light, 2: no idling
  int holds_requested = 0;

  // Returns 1 on the last cell of a map, with the winning square in sq.
  function automatic bit predict_cell(input cell_item_t c, output result_item_t sq);
    int unsigned w, col, row, up, lf, dg, m, s, tr, tc;
    w = width_cfg;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    col = col_pos;
    row = row_pos;
    up  = (row > 0) ? line_sizes[col] : 0;
    lf  = (col > 0) ? run_left : 0;
    dg  = (row > 0 && col > 0) ? run_diag : 0;
    m   = (up < lf) ? up : lf;
    m   = (m < dg) ? m : dg;
    s   = (c.cell_char == obst_cfg) ? 0 : m + 1;
    if (s > SIZE_MAX) s = SIZE_MAX;
    line_sizes[col] = s;
    run_diag = up;
    run_left = s;
    // Bigger square wins; on a tie the top-left corner nearest the top, then left.
    if (s > 0) begin
      tr = (row + 1 >= s) ? row + 1 - s : 0;
      tc = (col + 1 >= s) ? col + 1 - s : 0;
      if (s > best_sz || (s == best_sz && (tr < best_r || (tr == best_r && tc < best_c)))) begin
        best_sz = s;
        best_r  = tr;
        best_c  = tc;
      end
    end
    // Row wraps on the column that reaches the effective width.
    if (col + 1 >= w) begin
      col_pos  = 0;
      run_left = 0;
      run_diag = 0;
      if (row_pos < MAX_H - 1) row_pos++;
    end else begin
      col_pos = col + 1;
    end
    sq.square_size = SIZE_W'(best_sz);
    sq.top_row     = ROW_OUT_W'(best_r);
    sq.left_col    = COL_OUT_W'(best_c);
    if (!c.last_cell) return 1'b0;
    // End of map: scan state starts over for the next one.
    run_left = 0;
    run_diag = 0;
    col_pos  = 0;
    row_pos  = 0;
    best_sz  = 0;
    best_r   = 0;
    best_c   = 0;
    return 1'b1;
  endfunction

  function automatic int send_idle_pct(input int mode);
    case (mode)
      0:       return 6;
      1:       return 51;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(input int mode);
    case (mode)
      0:       return 51;
      1:       return 6;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one cell, holds it until taken, then predicts. typed: use exp_sq as
  // the expected square instead of the predictor's.
  task automatic send_cell(input cell_item_t c, input bit typed, input result_item_t exp_sq);
    result_item_t sq;
    while ($urandom_range(99) < send_idle_pct(idle_mode)) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_data  <= c;
    do @(posedge clk); while (!cell_ready);
    cells_sent++;
    if (predict_cell(c, sq)) begin
      pending_squares.push_back(typed ? exp_sq : sq);
      maps_sent++;
    end
  endtask

  // Random map of n cells; last_cell on the final one. Short last rows come
  // from n not being a multiple of the width.
  task automatic send_map(input int unsigned n, input int unsigned obst_pct);
    cell_item_t c;
    for (int unsigned i = 0; i < n; i++) begin
      c.cell_char = ($urandom_range(99) < obst_pct) ? CHAR_W'(obst_cfg)
                                                    : CHAR_W'($urandom_range(255));
      c.last_cell = (i == n - 1);
      send_cell(c, 1'b0, '0);
    end
  endtask

  // Stop offering, wait for every pending square, then let the pipe settle.
  task automatic wait_drained();
    cell_valid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; dropping the write enable before returning keeps back-to-back writes clean.
  task automatic set_reg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    case (sel)
      REG_MAP_WIDTH:     width_cfg = data;
      REG_OBSTACLE_CHAR: obst_cfg  = data[CHAR_W-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, long hold-offs on request, result checks.
  // ---------------------------------------------------------------------------
  task automatic check_square(input result_item_t got);
    result_item_t want;
    if (pending_squares.size() == 0) begin
      $error("unexpected result item: size %0d row %0d col %0d",
             got.square_size, got.top_row, got.left_col);
      mismatches++;
      return;
    end
    want = pending_squares.pop_front();
    squares_checked++;
    if (got.square_size !== want.square_size) begin
      $error("square_size: expected %0d, got %0d", want.square_size, got.square_size);
      mismatches++;
    end
    if (got.top_row !== want.top_row) begin
      $error("top_row: expected %0d, got %0d", want.top_row, got.top_row);
      mismatches++;
    end
    if (got.left_col !== want.left_col) begin
      $error("left_col: expected %0d, got %0d", want.left_col, got.left_col);
      mismatches++;
    end
  endtask

  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) check_square(result_data);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (holds_done != holds_requested) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct(idle_mode));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed items: typed expectations where the answer is obvious.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {
    ROW_CELL,      // checked against the predictor
    ROW_CHECKED,   // expected square typed in
    ROW_REG        // register write between maps
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_reg_e              cfg_sel;
    logic [CFG_DATA_W-1:0] cfg_data;
    cell_item_t            c;
    result_item_t          sq;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // width 1, obstacle 111 out of reset
    '{ROW_CHECKED, REG_MAP_WIDTH, 11'd0, '{8'd111, 1'b1}, '{11'd0, 10'd0, 10'd0}}, // all blocked
    '{ROW_CHECKED, REG_MAP_WIDTH, 11'd0, '{8'd0,   1'b1}, '{11'd1, 10'd0, 10'd0}},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd255, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd111, 1'b0}, '0},
    '{ROW_CHECKED, REG_MAP_WIDTH, 11'd0, '{8'd255, 1'b1}, '{11'd1, 10'd0, 10'd0}},
    // 3x2 all free: ties along row 0 resolve leftmost
    '{ROW_REG,     REG_MAP_WIDTH, 11'd3, '0, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd46, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd46, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd46, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd46, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd46, 1'b0}, '0},
    '{ROW_CHECKED, REG_MAP_WIDTH, 11'd0, '{8'd46, 1'b1}, '{11'd2, 10'd0, 10'd0}},
    // obstacle 255, short last row
    '{ROW_REG,     REG_OBSTACLE_CHAR, 11'd255, '0, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd255, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd0,   1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd0,   1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd0,   1'b1}, '0},
    // zero width behaves as one
    '{ROW_REG,     REG_MAP_WIDTH, 11'd0, '0, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd0,   1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd255, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd0,   1'b1}, '0},
    // oversize width clamps; lone obstacle gives the empty answer
    '{ROW_REG,     REG_MAP_WIDTH, 11'd2047, '0, '0},
    '{ROW_CHECKED, REG_MAP_WIDTH, 11'd0, '{8'd255, 1'b1}, '{11'd0, 10'd0, 10'd0}},
    // 2x2 with top-left blocked: topmost beats leftmost on a tie
    '{ROW_REG,     REG_OBSTACLE_CHAR, 11'd0, '0, '0},
    '{ROW_REG,     REG_MAP_WIDTH, 11'd2, '0, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd0, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd1, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd1, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd1, 1'b1}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd128, 1'b0}, '0},
    '{ROW_CELL,    REG_MAP_WIDTH, 11'd0, '{8'd127, 1'b1}, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned w, weff, n, first_cell, first_map;
    rst          <= 1'b1;
    cell_valid   <= 1'b0;
    cell_data    <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= REG_MAP_WIDTH;
    cfg_wdata    <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        wait_drained();
        set_reg(directed_rows[i].cfg_sel, directed_rows[i].cfg_data);
      end else begin
        send_cell(directed_rows[i].c, directed_rows[i].kind == ROW_CHECKED,
                  directed_rows[i].sq);
      end
    end

    // Random maps: a new width/obstacle setting every four maps, idling
    // style moving through the three modes as cells go by.
    first_cell = cells_sent;
    first_map  = maps_sent;
    while (cells_sent - first_cell < RAND_CELLS || maps_sent - first_map < RAND_MAPS) begin
      idle_mode = ((cells_sent - first_cell) * 3) / RAND_CELLS;
      if (idle_mode > 2) idle_mode = 2;
      wait_drained();
      case ($urandom_range(15))
        0:       w = 0;
        1:       w = 2047;
        2:       w = MAX_W;
        3:       w = $urandom_range(MAX_W + 1, 2046);
        default: w = $urandom_range(1, 12);
      endcase
      set_reg(REG_MAP_WIDTH, CFG_DATA_W'(w));
      set_reg(REG_OBSTACLE_CHAR, CFG_DATA_W'($urandom_range(255)));
      settings_used++;
      weff = (w < 1) ? 1 : (w > MAX_W) ? MAX_W : w;
      repeat (4) begin
        // Wide settings get single-row maps to keep the run short.
        n = (weff > 16) ? $urandom_range(1, 40) : weff * $urandom_range(1, 5);
        if ($urandom_range(3) == 0) n = $urandom_range(1, n);
        send_map(n, $urandom_range(0, 40));
      end
    end

    // Back-pressure: the receiver holds off while one-cell maps keep coming,
    // so the result register fills and the input stalls.
    idle_mode = 2;
    wait_drained();
    holds_requested <= holds_requested + 1;
    repeat (12) send_map(1, 30);

    wait_drained();
    $display("Ran %0d cells as %0d maps over %0d register settings; %0d squares compared.",
             cells_sent, maps_sent, settings_used, squares_checked);
    if (mismatches == 0) begin
      $display("** largest_empty_square_finder_core: PASSED **");
    end else begin
      $display("** largest_empty_square_finder_core: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d squares still pending.", pending_squares.size());
    $display("** largest_empty_square_finder_core: FAILED **");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/lesf_pkg.sv
rtl/core/lesf_best.sv
rtl/core/largest_empty_square_finder_core.sv
verif/largest_empty_square_finder_core_tb.sv
